[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers for the rtl files, included by ps2ht_core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge, disabled while reset is high
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising clock edge, also during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ps2ht_pkg.sv]
// ----------------------------------------------------------------------------
// ps2ht_pkg
// types and constants of the ps/2 host command transmitter
// ----------------------------------------------------------------------------
package ps2ht_pkg;

   localparam int unsigned DATA_BITS      = 8;
   localparam int unsigned CNT_WIDTH      = 16;
   localparam int unsigned CSR_IDX_WIDTH  = 2;

   localparam logic [3:0]           BITS_LOAD       = 4'(DATA_BITS + 1);
   localparam logic [CNT_WIDTH-1:0] TIMEOUT_RESET   = 16'd60000;
   localparam logic [CNT_WIDTH-1:0] INHIBIT_RESET   = 16'd150;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TIMEOUT_TICKS = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INHIBIT_TICKS = 2'd1;

   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_FIRST_EDGE  = 3'd1;
   localparam logic [2:0] STATUS_ACK_DATA    = 3'd2;
   localparam logic [2:0] STATUS_ACK_CLOCK   = 3'd3;
   localparam logic [2:0] STATUS_RELEASE     = 3'd4;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_INHIBIT,
      PH_FIRST,
      PH_BITS,
      PH_ACK_DATA,
      PH_ACK_CLOCK,
      PH_RELEASE
   } phase_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] command;
      logic       clock_line;
      logic       data_line;
   } req_payload_type;

   typedef struct packed {
      logic       clock_pull_low;
      logic       data_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [2:0] status;
   } rsp_payload_type;

   typedef struct packed {
      logic [CNT_WIDTH-1:0] timeout_ticks;
      logic [CNT_WIDTH-1:0] inhibit_ticks;
   } cfg_type;

endpackage

[hdl/ps2ht_csr.sv]
// ----------------------------------------------------------------------------
// ps2ht_csr
// configuration registers, written over the csr channel
// ----------------------------------------------------------------------------
module ps2ht_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ps2ht_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [ps2ht_pkg::CNT_WIDTH-1:0]       csr_data,
   output ps2ht_pkg::cfg_type                    cfg
);
   import ps2ht_pkg::*;

   logic [CNT_WIDTH-1:0] timeout_ff, timeout_in;
   logic [CNT_WIDTH-1:0] inhibit_ff, inhibit_in;

   assign csr_ready = 1'b1;

   always_comb begin
      timeout_in = timeout_ff;
      inhibit_in = inhibit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TIMEOUT_TICKS: timeout_in = csr_data;
            CSR_INHIBIT_TICKS: inhibit_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         inhibit_ff <= INHIBIT_RESET;
      end else begin
         timeout_ff <= timeout_in;
         inhibit_ff <= inhibit_in;
      end
   end

   assign cfg.timeout_ticks = timeout_ff;
   assign cfg.inhibit_ticks = inhibit_ff;

endmodule

[hdl/ps2ht_core.sv]
// ----------------------------------------------------------------------------
// ps2ht_core
// transfer state machine, one transaction per cycle while accept is high, result from next state
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2ht_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  ps2ht_pkg::req_payload_type  req,
   input  ps2ht_pkg::cfg_type          cfg,
   output ps2ht_pkg::rsp_payload_type  rsp_next
);
   import ps2ht_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [7:0]           shift_ff, shift_in;
   logic [3:0]           bits_left_ff, bits_left_in;
   logic                 parity_ff, parity_in;
   logic                 await_high_ff, await_high_in;
   logic [CNT_WIDTH-1:0] wait_cnt_ff, wait_cnt_in;
   logic [2:0]           status_ff, status_in;
   logic                 done;

   logic [CNT_WIDTH-1:0] tmo_lim, inh_lim;
   logic [CNT_WIDTH:0]   wait_inc;
   logic                 wait_cond, wait_hit, wait_tmo;
   logic [CNT_WIDTH-1:0] wait_cnt_step;
   logic                 cur_bit;

   assign tmo_lim = (cfg.timeout_ticks == '0) ? CNT_WIDTH'(1) : cfg.timeout_ticks;
   assign inh_lim = (cfg.inhibit_ticks == '0) ? CNT_WIDTH'(1) : cfg.inhibit_ticks;
   assign wait_inc = {1'b0, wait_cnt_ff} + (CNT_WIDTH+1)'(1);

   // line condition that ends the current wait
   always_comb begin
      unique case (phase_ff)
         PH_FIRST:     wait_cond = !req.clock_line;
         PH_BITS:      wait_cond = await_high_ff ? req.clock_line : !req.clock_line;
         PH_ACK_DATA:  wait_cond = !req.data_line;
         PH_ACK_CLOCK: wait_cond = !req.clock_line;
         PH_RELEASE:   wait_cond = req.data_line || req.clock_line;
         default:      wait_cond = 1'b0;
      endcase
   end

   assign wait_hit      = wait_cond;
   assign wait_tmo      = !wait_cond && (wait_inc >= {1'b0, tmo_lim});
   assign wait_cnt_step = (wait_hit || wait_tmo) ? '0 : wait_inc[CNT_WIDTH-1:0];

   // next state
   always_comb begin
      phase_in      = phase_ff;
      shift_in      = shift_ff;
      bits_left_in  = bits_left_ff;
      parity_in     = parity_ff;
      await_high_in = await_high_ff;
      wait_cnt_in   = wait_cnt_ff;
      status_in     = status_ff;
      done          = 1'b0;
      if (accept) begin
         if (req.req_type) begin
            if (phase_ff == PH_IDLE) begin
               shift_in      = req.command;
               bits_left_in  = BITS_LOAD;
               parity_in     = 1'b1;
               await_high_in = 1'b0;
               wait_cnt_in   = '0;
               phase_in      = PH_INHIBIT;
            end
         end else begin
            unique case (phase_ff)
               PH_INHIBIT: begin
                  if (wait_inc[CNT_WIDTH-1:0] >= inh_lim) begin
                     wait_cnt_in = '0;
                     phase_in    = PH_FIRST;
                  end else begin
                     wait_cnt_in = wait_inc[CNT_WIDTH-1:0];
                  end
               end
               PH_FIRST: begin
                  wait_cnt_in = wait_cnt_step;
                  if (wait_hit) begin
                     phase_in      = PH_BITS;
                     await_high_in = 1'b1;
                  end else if (wait_tmo) begin
                     status_in = STATUS_FIRST_EDGE;
                     phase_in  = PH_IDLE;
                     done      = 1'b1;
                  end
               end
               PH_BITS: begin
                  wait_cnt_in = wait_cnt_step;
                  if (await_high_ff) begin
                     if (wait_hit || wait_tmo) await_high_in = 1'b0;
                  end else if (wait_hit || wait_tmo) begin
                     if (bits_left_ff > 4'd1) begin
                        parity_in     = parity_ff ^ shift_ff[0];
                        shift_in      = {1'b0, shift_ff[7:1]};
                        bits_left_in  = bits_left_ff - 4'd1;
                        await_high_in = 1'b1;
                     end else begin
                        bits_left_in = '0;
                        phase_in     = PH_ACK_DATA;
                     end
                  end
               end
               PH_ACK_DATA: begin
                  wait_cnt_in = wait_cnt_step;
                  if (wait_hit) begin
                     phase_in = PH_ACK_CLOCK;
                  end else if (wait_tmo) begin
                     status_in     = STATUS_ACK_DATA;
                     phase_in      = PH_IDLE;
                     await_high_in = 1'b0;
                     done          = 1'b1;
                  end
               end
               PH_ACK_CLOCK: begin
                  wait_cnt_in = wait_cnt_step;
                  if (wait_hit) begin
                     phase_in = PH_RELEASE;
                  end else if (wait_tmo) begin
                     status_in     = STATUS_ACK_CLOCK;
                     phase_in      = PH_IDLE;
                     await_high_in = 1'b0;
                     done          = 1'b1;
                  end
               end
               PH_RELEASE: begin
                  wait_cnt_in = wait_cnt_step;
                  if (wait_hit || wait_tmo) begin
                     status_in     = wait_hit ? STATUS_OK : STATUS_RELEASE;
                     phase_in      = PH_IDLE;
                     await_high_in = 1'b0;
                     done          = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // outputs from the updated state
   always_comb begin
      cur_bit = (bits_left_in > 4'd1) ? shift_in[0] : parity_in;
      rsp_next.clock_pull_low = 1'b0;
      rsp_next.data_pull_low  = 1'b0;
      unique case (phase_in)
         PH_INHIBIT: rsp_next.clock_pull_low = 1'b1;
         PH_FIRST:   rsp_next.data_pull_low  = 1'b1;
         PH_BITS:    rsp_next.data_pull_low  = !cur_bit;
         default: ;
      endcase
      rsp_next.busy_res = (phase_in != PH_IDLE);
      rsp_next.done_res = done;
      rsp_next.status   = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         shift_ff      <= '0;
         bits_left_ff  <= '0;
         parity_ff     <= 1'b1;
         await_high_ff <= 1'b0;
         wait_cnt_ff   <= '0;
         status_ff     <= STATUS_OK;
      end else begin
         phase_ff      <= phase_in;
         shift_ff      <= shift_in;
         bits_left_ff  <= bits_left_in;
         parity_ff     <= parity_in;
         await_high_ff <= await_high_in;
         wait_cnt_ff   <= wait_cnt_in;
         status_ff     <= status_in;
      end
   end

   `ASSERT_CLK_RST(a_idle_cnt_zero, clock, reset,
      (phase_ff == PH_IDLE) |-> (wait_cnt_ff == '0), "wait count not cleared in idle")
   `ASSERT_CLK_RST(a_done_to_idle, clock, reset,
      (accept && rsp_next.done_res) |=> (phase_ff == PH_IDLE), "done without return to idle")
   `ASSERT_CLK_RST(a_hold_no_accept, clock, reset,
      !accept |=> ($stable(phase_ff) && $stable(wait_cnt_ff)), "state moved without a transaction")
   `ASSERT_CLK_RST(a_idle_tick, clock, reset,
      (accept && !req.req_type && phase_ff == PH_IDLE) |=> (phase_ff == PH_IDLE), "tick left idle")
   `ASSERT_CLK_RST(a_bits_range, clock, reset,
      bits_left_ff <= BITS_LOAD, "bit count out of range")

endmodule

[hdl/ps2_host_command_transmitter.sv]
// output: a result is held in the output register from the cycle after its transaction
// throughput: one transaction per cycle; the output register parts the two sides,
//   and the input stalls only while a held result is itself stalled
// reset: synchronous, active high; idle phase, status 0, config registers to
//   timeout 60000 and inhibit 150, output register empty
// ----------------------------------------------------------------------------
// ps2_host_command_transmitter
// host side of a ps/2 command send: inhibit, start bit, data, parity, ack
// ----------------------------------------------------------------------------
module ps2_host_command_transmitter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ps2ht_pkg::req_payload_type            req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ps2ht_pkg::rsp_payload_type            rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ps2ht_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [ps2ht_pkg::CNT_WIDTH-1:0]       csr_data
);
   import ps2ht_pkg::*;

   cfg_type         cfg;
   rsp_payload_type rsp_next;
   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            accept;

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   ps2ht_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ps2ht_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_payload),
      .cfg      (cfg),
      .rsp_next (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
